>>> hdl/assert_macros.svh
// Assertion helpers included by the handle table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/rcyid_pkg.sv
package rcyid_pkg;

  // Default sizes of the table.
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // Fixed port field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_GET    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

>>> hdl/rcyid_ram.sv
module rcyid_ram
  import rcyid_pkg::*;
#(
  parameter int unsigned Depth = TABLE_DEPTH_DEF,
  parameter int unsigned Width = HANDLE_BITS_DEF + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/recycling_id_handle_table_core.sv
// Recycling handle table. Each command beat (add, remove, update or get) yields one result
// beat carrying a status, an ID, a handle and the live count after the command. Add takes
// the most recently freed ID if there is one, otherwise the next never-used ID, and reports
// full when neither exists. A command is handled in two steps: the synchronous read of the
// entry memory and the free-ID stack, then the decision and the write-back; the write-back
// waits only while a finished result is still held by the output stall. A new command is
// taken in the cycle after the write-back, so no read ever overlaps a pending write. There is
// no clearing pass after reset: an ID at or above the number of IDs ever handed out is
// treated as free without reading the memory, so the table is usable straight out of reset.
module recycling_id_handle_table_core
  import rcyid_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [ID_W-1:0]        entry_id_i,
  input  logic [HANDLE_BITS-1:0] handle_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [ID_W-1:0]        assigned_id_o,
  output logic [HANDLE_BITS-1:0] handle_out_o,
  output logic [COUNT_W-1:0]     live_count_o
);

`include "assert_macros.svh"

  localparam int unsigned IdW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW  = HANDLE_BITS + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic in_accept;
  logic out_ready;
  logic exec_fire;
  logic mem_re;

  // Captured command.
  cmd_e                   cmd_q;
  logic [ID_W-1:0]        entry_id_q;
  logic                   in_range_q;
  logic [IdW-1:0]         idx_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [31:0]            id_wide;

  // Table bookkeeping.
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] free_q, free_d;
  logic [CntW-1:0] free_m1;
  logic [CntW:0]   high_water;

  // Memory ports.
  logic            ent_we, ent_we_gated;
  logic [IdW-1:0]  ent_waddr;
  logic [EntW-1:0] ent_wdata;
  logic [EntW-1:0] ent_rdata;
  logic            stk_we, stk_we_gated;
  logic [IdW-1:0]  stk_waddr;
  logic [IdW-1:0]  stk_wdata;
  logic [IdW-1:0]  stk_raddr;
  logic [IdW-1:0]  stk_rdata;

  // Decision results.
  logic                   id_live;
  logic [IdW-1:0]         new_id;
  logic [31:0]            new_id_wide;
  logic [31:0]            cnt_wide;
  status_e                res_status;
  logic [ID_W-1:0]        res_id;
  logic [HANDLE_BITS-1:0] res_handle;

  // Output register.
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [ID_W-1:0]        assigned_q;
  logic [HANDLE_BITS-1:0] hout_q;
  logic [COUNT_W-1:0]     live_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    exec_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_re     = in_valid_i;
      end
      ST_EXEC: begin
        exec_fire = out_ready;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the command beat and its memory index.
  assign id_wide = 32'(entry_id_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= cmd_e'(cmd_i);
      entry_id_q <= entry_id_i;
      in_range_q <= (id_wide < TABLE_DEPTH);
      idx_q      <= id_wide[IdW-1:0];
      handle_q   <= handle_in_i;
    end
  end

  // The top of the free-ID stack is read alongside the entry.
  assign free_m1   = free_q - CntW'(1);
  assign stk_raddr = free_m1[IdW-1:0];

  rcyid_ram #(
    .Depth (TABLE_DEPTH),
    .Width (EntW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we_gated),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (mem_re),
    .raddr_i (id_wide[IdW-1:0]),
    .rdata_o (ent_rdata)
  );

  rcyid_ram #(
    .Depth (TABLE_DEPTH),
    .Width (IdW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we_gated),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (mem_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Every ID below the high-water mark has been written at least once.
  assign high_water = {1'b0, used_q} + {1'b0, free_q};
  assign id_live    = in_range_q && ((CntW + 1)'(idx_q) < high_water) && ent_rdata[HANDLE_BITS];

  assign new_id      = (free_q != '0) ? stk_rdata : used_q[IdW-1:0];
  assign new_id_wide = 32'(new_id);

  // Decide the command and prepare the write-back.
  always_comb begin
    res_status = STATUS_OK;
    res_id     = entry_id_q;
    res_handle = '0;
    used_d     = used_q;
    free_d     = free_q;
    ent_we     = 1'b0;
    ent_waddr  = idx_q;
    ent_wdata  = {1'b1, handle_q};
    stk_we     = 1'b0;
    stk_waddr  = free_q[IdW-1:0];
    stk_wdata  = idx_q;
    unique case (cmd_q)
      CMD_ADD: begin
        if (free_q != '0 || used_q != DepthCnt) begin
          ent_we    = 1'b1;
          ent_waddr = new_id;
          used_d    = used_q + CntW'(1);
          res_id    = new_id_wide[ID_W-1:0];
          if (free_q != '0) begin
            free_d = free_m1;
          end
        end else begin
          res_status = STATUS_FULL;
          res_id     = '0;
        end
      end
      CMD_REMOVE: begin
        if (!id_live) begin
          res_status = STATUS_NOT_FOUND;
        end else begin
          res_handle = ent_rdata[HANDLE_BITS-1:0];
          ent_we     = 1'b1;
          ent_wdata  = {1'b0, handle_q};
          if (used_q != '0) begin
            used_d = used_q - CntW'(1);
          end
          if (free_q != DepthCnt) begin
            stk_we = 1'b1;
            free_d = free_q + CntW'(1);
          end
        end
      end
      CMD_UPDATE: begin
        if (!id_live) begin
          res_status = STATUS_NOT_FOUND;
        end else begin
          ent_we = 1'b1;
        end
      end
      CMD_GET: begin
        if (!id_live) begin
          res_status = STATUS_NOT_FOUND;
        end else begin
          res_handle = ent_rdata[HANDLE_BITS-1:0];
        end
      end
      default: res_status = STATUS_NOT_FOUND;
    endcase
  end

  assign ent_we_gated = exec_fire && ent_we;
  assign stk_we_gated = exec_fire && stk_we;
  assign cnt_wide     = 32'(used_d);

  // Counters move only when the result is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      free_q <= '0;
    end else if (exec_fire) begin
      used_q <= used_d;
      free_q <= free_d;
    end
  end

  // Output register: a result beat waits here while the next command is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q   <= res_status;
      assigned_q <= res_id;
      hout_q     <= res_handle;
      live_q     <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign assigned_id_o = assigned_q;
  assign handle_out_o  = hout_q;
  assign live_count_o  = live_q;

  // Live and freed IDs together never exceed the table.
  `ASSERT_NEVER(a_occupancy, clk_i, rst_ni, high_water > (CntW + 1)'(TABLE_DEPTH), "ID count beyond table depth")
  // A committed command always leaves a result beat behind.
  `ASSERT_PROP(a_fire_result, clk_i, rst_ni, exec_fire |=> (out_valid_q && state_q == ST_IDLE), "result beat missing after commit")
  // The live count only moves on a committed command.
  `ASSERT_PROP(a_count_commit, clk_i, rst_ni, (used_q != $past(used_q)) |-> $past(exec_fire), "live count changed without a command")
  // The free stack only moves on a committed command.
  `ASSERT_PROP(a_free_commit, clk_i, rst_ni, (free_q != $past(free_q)) |-> $past(exec_fire), "free stack changed without a command")

endmodule
